FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

FILE: src/gbsd_pkg.sv
// ----------------------------------------------------------------------------
// gbsd_pkg
// types, widths and divisor setup shared by the golomb decoder modules
// ----------------------------------------------------------------------------
package gbsd_pkg;

   localparam int DIVISOR_BITS  = 16;
   localparam int QUOTIENT_BITS = 16;
   localparam int COUNT_BITS    = 5;
   localparam int VALUE_BITS    = 32;

   localparam logic [DIVISOR_BITS-1:0]  DIVISOR_RESET = 16'd5;
   localparam logic [QUOTIENT_BITS-1:0] QUOTIENT_MAX  = '1;

   typedef enum logic [1:0] {
      PH_UNARY  = 2'b01,
      PH_REMAIN = 2'b10
   } phase_type;

   typedef struct packed {
      logic [DIVISOR_BITS-1:0] divisor;
      logic [COUNT_BITS-1:0]   width;
      logic [DIVISOR_BITS-1:0] cutoff;
   } div_cfg_type;

   typedef struct packed {
      logic                     emit;
      logic [QUOTIENT_BITS-1:0] quotient;
      logic [DIVISOR_BITS-1:0]  remainder;
      logic                     overflow;
   } word_evt_type;

   function automatic div_cfg_type calc_cfg(input logic [DIVISOR_BITS-1:0] d);
      div_cfg_type             c;
      logic [DIVISOR_BITS-1:0] dm1;
      logic [DIVISOR_BITS:0]   pow;
      c.divisor = (d == '0) ? DIVISOR_BITS'(1) : d;
      dm1       = c.divisor - DIVISOR_BITS'(1);
      c.width   = '0;
      for (int i = 0; i < DIVISOR_BITS; i++) begin
         if (dm1[i]) begin
            c.width = COUNT_BITS'(i + 1);
         end
      end
      pow      = (DIVISOR_BITS+1)'(1) << c.width;
      c.cutoff = DIVISOR_BITS'(pow - {1'b0, c.divisor});
      return c;
   endfunction

endpackage

FILE: src/gbsd_parse.sv
// ----------------------------------------------------------------------------
// gbsd_parse
// codeword parser: unary quotient run, then truncated binary remainder
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gbsd_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 code_bit,
   input  gbsd_pkg::div_cfg_type cfg,
   output gbsd_pkg::word_evt_type evt
);

   gbsd_pkg::phase_type                     phase_ff, phase_in;
   logic [gbsd_pkg::QUOTIENT_BITS-1:0]      quot_ff, quot_in;
   logic [gbsd_pkg::DIVISOR_BITS-1:0]       acc_ff, acc_in;
   logic [gbsd_pkg::COUNT_BITS-1:0]         bits_ff, bits_in;
   logic                                    sat_ff, sat_in;

   logic [gbsd_pkg::DIVISOR_BITS-1:0]       acc_next;
   logic [gbsd_pkg::COUNT_BITS-1:0]         bits_next;

   assign acc_next  = {acc_ff[gbsd_pkg::DIVISOR_BITS-2:0], code_bit};
   assign bits_next = bits_ff + gbsd_pkg::COUNT_BITS'(1);

   always_comb begin
      phase_in      = phase_ff;
      quot_in       = quot_ff;
      acc_in        = acc_ff;
      bits_in       = bits_ff;
      sat_in        = sat_ff;
      evt.emit      = 1'b0;
      evt.quotient  = quot_ff;
      evt.remainder = '0;
      evt.overflow  = sat_ff;
      if (accept) begin
         unique case (phase_ff)
            gbsd_pkg::PH_UNARY: begin
               if (code_bit) begin
                  if (quot_ff == gbsd_pkg::QUOTIENT_MAX) begin
                     sat_in = 1'b1;
                  end else begin
                     quot_in = quot_ff + gbsd_pkg::QUOTIENT_BITS'(1);
                  end
               end else if (cfg.width == '0) begin
                  evt.emit = 1'b1;
               end else begin
                  phase_in = gbsd_pkg::PH_REMAIN;
                  acc_in   = '0;
                  bits_in  = '0;
               end
            end
            default: begin
               acc_in  = acc_next;
               bits_in = bits_next;
               if (bits_next >= cfg.width) begin
                  evt.emit      = 1'b1;
                  evt.remainder = (acc_next >= cfg.cutoff) ? acc_next - cfg.cutoff
                                                           : acc_next;
               end else if (bits_next == cfg.width - gbsd_pkg::COUNT_BITS'(1)
                            && acc_next < cfg.cutoff) begin
                  evt.emit      = 1'b1;
                  evt.remainder = acc_next;
               end
            end
         endcase
         if (evt.emit) begin
            phase_in = gbsd_pkg::PH_UNARY;
            quot_in  = '0;
            acc_in   = '0;
            bits_in  = '0;
            sat_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= gbsd_pkg::PH_UNARY;
         quot_ff  <= '0;
         acc_ff   <= '0;
         bits_ff  <= '0;
         sat_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         quot_ff  <= quot_in;
         acc_ff   <= acc_in;
         bits_ff  <= bits_in;
         sat_ff   <= sat_in;
      end
   end

   `ASSERT_PROP(a_sat_at_max, clock, reset, sat_ff |-> quot_ff == gbsd_pkg::QUOTIENT_MAX)
   `ASSERT_NEVER(a_acc_fits, clock, reset, (acc_ff >> bits_ff) != '0)
   `ASSERT_NEVER(a_emit_idle, clock, reset, evt.emit && !accept)

endmodule

FILE: src/golomb_bit_serial_decoder_core.sv
// ----------------------------------------------------------------------------
// golomb_bit_serial_decoder_core
// golomb decoder taking one code bit per word, truncated binary remainder
// ----------------------------------------------------------------------------
// req channel: one code bit per word, unary ones first, then a zero, then
//    the remainder bits msb first; codewords follow back to back
// rsp channel: one word per finished codeword with value = q * m + r and
//    the overflow flag of a saturated quotient run
// csr channel: writes the divisor m; csr_ready is always high, and a write
//    sets up the remainder width and cutoff for the following bits
// throughput: one code bit per cycle while req_stall is low; the parser and the q * m + r
//    multiply-add sit between the bit input and the rsp register
// output: the rsp word is registered and valid in the cycle after the bit that ends it
// stall: a stalled rsp word holds; req_stall rises only while a rsp word
//    waits under rsp_stall
// reset: divisor returns to 5, the parser restarts at a fresh codeword and
//    the rsp register is emptied
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module golomb_bit_serial_decoder_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_code_bit,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [gbsd_pkg::VALUE_BITS-1:0]    rsp_value,
   output logic                               rsp_overflow,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gbsd_pkg::DIVISOR_BITS-1:0]  csr_divisor
);

   gbsd_pkg::div_cfg_type                cfg_ff, cfg_in;
   gbsd_pkg::word_evt_type               evt;
   logic                                 req_accept;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [gbsd_pkg::VALUE_BITS-1:0]      value_ff, value_in;
   logic                                 ovf_ff, ovf_in;
   logic [gbsd_pkg::VALUE_BITS-1:0]      product;

   assign csr_ready  = 1'b1;
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign cfg_in = (csr_valid && csr_ready) ? gbsd_pkg::calc_cfg(csr_divisor) : cfg_ff;

   gbsd_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .code_bit (req_code_bit),
      .cfg      (cfg_ff),
      .evt      (evt)
   );

   assign product = gbsd_pkg::VALUE_BITS'(
      {{(gbsd_pkg::VALUE_BITS-gbsd_pkg::QUOTIENT_BITS){1'b0}}, evt.quotient} *
      {{(gbsd_pkg::VALUE_BITS-gbsd_pkg::DIVISOR_BITS){1'b0}}, cfg_ff.divisor});

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      value_in     = value_ff;
      ovf_in       = ovf_ff;
      if (evt.emit) begin
         rsp_valid_in = 1'b1;
         value_in     = product + gbsd_pkg::VALUE_BITS'(evt.remainder);
         ovf_in       = evt.overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= gbsd_pkg::calc_cfg(gbsd_pkg::DIVISOR_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      ovf_ff   <= ovf_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = value_ff;
   assign rsp_overflow = ovf_ff;

   `ASSERT_PROP(a_emit_shows, clock, reset, evt.emit |=> rsp_valid_ff)
   `ASSERT_NEVER(a_no_overwrite, clock, reset, evt.emit && rsp_valid_ff && rsp_stall)
   `ASSERT_PROP(a_cutoff_below, clock, reset, cfg_ff.cutoff < cfg_ff.divisor)

endmodule

FILE: test/golomb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// golomb_checker
// watches the req, rsp and csr channels of the golomb decoder, decodes the
// accepted code bits on its own and compares every rsp word in order
// ----------------------------------------------------------------------------
module golomb_checker
   import gbsd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic                    req_code_bit,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [VALUE_BITS-1:0]   rsp_value,
   input  logic                    rsp_overflow,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [DIVISOR_BITS-1:0] csr_divisor,
   output int                      fail_count,
   output int                      pending_words
);

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  overflow;
   } decoded_word_type;

   decoded_word_type          decoded_words[$];
   logic [DIVISOR_BITS-1:0]   divisor_q;
   phase_type                 phase_q;
   logic [QUOTIENT_BITS-1:0]  ones_q;
   logic [DIVISOR_BITS-1:0]   remainder_q;
   logic [COUNT_BITS-1:0]     bits_q;
   logic                      saturated_q;
   int                        errors;

   initial begin
      fail_count    = 0;
      pending_words = 0;
      errors        = 0;
   end

   task automatic restart_codeword();
      phase_q     = PH_UNARY;
      ones_q      = '0;
      remainder_q = '0;
      bits_q      = '0;
      saturated_q = 1'b0;
   endtask

   task automatic finish_codeword(input int m, input int rem);
      decoded_word_type w;
      longint           v;
      v          = longint'(ones_q) * m + rem;
      w.value    = VALUE_BITS'(v);
      w.overflow = saturated_q;
      decoded_words = {decoded_words, w};
      restart_codeword();
   endtask

   task automatic decode_bit(input logic b);
      int m;
      int width;
      int cut;
      m     = (divisor_q == '0) ? 1 : int'(divisor_q);
      width = 0;
      while ((1 << width) < m) width++;
      cut = (1 << width) - m;
      if (phase_q == PH_UNARY) begin
         if (b) begin
            if (ones_q == QUOTIENT_MAX) saturated_q = 1'b1;
            else ones_q++;
         end else if (width == 0) begin
            finish_codeword(m, 0);
         end else begin
            phase_q     = PH_REMAIN;
            remainder_q = '0;
            bits_q      = '0;
         end
      end else begin
         remainder_q = {remainder_q[DIVISOR_BITS-2:0], b};
         bits_q++;
         if (int'(bits_q) >= width) begin
            if (int'(remainder_q) >= cut) finish_codeword(m, int'(remainder_q) - cut);
            else finish_codeword(m, int'(remainder_q));
         end else if (int'(bits_q) == width - 1 && int'(remainder_q) < cut) begin
            finish_codeword(m, int'(remainder_q));
         end
      end
   endtask

   always @(posedge clock) begin
      decoded_word_type w;
      if (reset) begin
         divisor_q = DIVISOR_RESET;
         restart_codeword();
         decoded_words.delete();
      end else begin
         if (csr_valid && csr_ready) divisor_q = csr_divisor;
         if (req_valid && !req_stall) decode_bit(req_code_bit);
         if (rsp_valid && !rsp_stall) begin
            if (decoded_words.size() == 0) begin
               $error("rsp word with nothing expected: value %0h overflow %0b",
                      rsp_value, rsp_overflow);
               errors++;
            end else begin
               w = decoded_words.pop_front();
               if (rsp_value !== w.value) begin
                  $error("value: expected %0h, actual %0h", w.value, rsp_value);
                  errors++;
               end
               if (rsp_overflow !== w.overflow) begin
                  $error("overflow: expected %0b, actual %0b", w.overflow, rsp_overflow);
                  errors++;
               end
            end
         end
      end
      fail_count    <= errors;
      pending_words <= decoded_words.size();
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives golomb codewords and noise bits into the decoder under several
// divisors with random gaps and stalls, and gives the verdict of the checker
// ----------------------------------------------------------------------------
module testbench;

   import gbsd_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int LONG_HOLD   = 400;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_code_bit = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [VALUE_BITS-1:0]   rsp_value;
   logic                    rsp_overflow;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [DIVISOR_BITS-1:0] csr_divisor = '0;

   int                      fail_count;
   int                      pending_words;
   int                      cycle_count = 0;
   int                      bits_sent = 0;
   bit                      idle_on = 1'b1;
   bit                      long_hold_pending = 1'b0;
   logic [DIVISOR_BITS-1:0] cur_divisor = DIVISOR_RESET;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   golomb_bit_serial_decoder_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_code_bit (req_code_bit),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_value    (rsp_value),
      .rsp_overflow (rsp_overflow),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_divisor  (csr_divisor)
   );

   golomb_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_code_bit  (req_code_bit),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_overflow  (rsp_overflow),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_divisor   (csr_divisor),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("golomb_bit_serial_decoder_core regression: fail");
         $finish;
      end
   end

   // rsp side: random stall after each word, plus one long hold
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!reset && rsp_valid && !rsp_stall) begin
            n = idle_on ? $urandom_range(0, 13) : 0;
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   task automatic send_bit(input logic b);
      int gap;
      gap = idle_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_code_bit <= b;
      do @(posedge clock); while (req_stall);
      bits_sent++;
   endtask

   task automatic send_codeword(input int q, input int r);
      int m;
      int width;
      int cut;
      int code;
      int n;
      m     = (cur_divisor == '0) ? 1 : int'(cur_divisor);
      width = 0;
      while ((1 << width) < m) width++;
      cut = (1 << width) - m;
      repeat (q) send_bit(1'b1);
      send_bit(1'b0);
      if (width > 0) begin
         if (r < cut) begin
            code = r;
            n    = width - 1;
         end else begin
            code = r + cut;
            n    = width;
         end
         for (int i = n - 1; i >= 0; i--) send_bit(code[i]);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_divisor(input logic [DIVISOR_BITS-1:0] d);
      wait_for_drain();
      csr_valid   <= 1'b1;
      csr_divisor <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      cur_divisor = d;
   endtask

   // mostly well formed codewords, some random noise bits
   task automatic run_random(input int n_bits, input bit mid_drain);
      int start;
      int m;
      int q;
      bit drained;
      start   = bits_sent;
      drained = 1'b0;
      m       = (cur_divisor == '0) ? 1 : int'(cur_divisor);
      while (bits_sent - start < n_bits) begin
         if ($urandom_range(0, 9) == 0) idle_on = !idle_on;
         if (mid_drain && !drained && bits_sent - start > n_bits / 2) begin
            wait_for_drain();
            drained = 1'b1;
         end
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 6)) send_bit(1'($urandom_range(0, 1)));
         end else begin
            q = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5);
            send_codeword(q, $urandom_range(0, m - 1));
         end
      end
   endtask

   initial begin
      logic [DIVISOR_BITS-1:0] divisors[12];
      divisors = '{16'd2, 16'd3, 16'd32768, 16'd32769, 16'd7, 16'd5, 16'd65535,
                   16'd0, 16'd1, 16'd0, 16'd0, 16'd0};
      for (int i = 9; i < 12; i++) divisors[i] = DIVISOR_BITS'($urandom_range(2, 65535));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset divisor 5: short and long remainder forms
      send_codeword(0, 0);
      send_codeword(0, 2);
      send_codeword(0, 3);
      send_codeword(1, 4);
      send_codeword(3, 1);

      // divisor zero acts as one, no remainder bits
      write_divisor(16'd0);
      send_codeword(2, 0);
      send_codeword(0, 0);
      write_divisor(16'd1);
      send_codeword(0, 0);
      send_codeword(1, 0);

      idle_on = 1'b0;
      write_divisor(16'd65535);
      send_codeword(0, 0);
      send_codeword(0, 65534);

      // divisor change in the middle of a remainder
      idle_on = 1'b1;
      send_bit(1'b1);
      send_bit(1'b0);
      repeat (10) send_bit(1'($urandom_range(0, 1)));
      write_divisor(16'd5);
      repeat (3) send_bit(1'($urandom_range(0, 1)));
      send_codeword(0, 1);

      for (int p = 0; p < 12; p++) begin
         write_divisor(divisors[p]);
         if (p == 3) long_hold_pending = 1'b1;
         run_random(160, p == 5);
      end

      wait_for_drain();
      if (fail_count == 0) begin
         $display("golomb_bit_serial_decoder_core regression: pass");
      end else begin
         $display("golomb_bit_serial_decoder_core regression: fail");
      end
      $finish;
   end

endmodule
